### rtl/core/m3i_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int ElemW     = 32;
  localparam int AdjW      = 64;
  localparam int TolW      = 16;
  localparam int QuotW     = 33;
  localparam int FrontLat  = 5;
  localparam int LaneLat   = QuotW + 1;
  localparam logic [TolW-1:0] TolReset = 16'd7;
  localparam logic signed [ElemW:0] OneQ16 = 33'sd65536;

  typedef struct packed {
    logic signed [ElemW-1:0] a00;
    logic signed [ElemW-1:0] a01;
    logic signed [ElemW-1:0] a02;
    logic signed [ElemW-1:0] a10;
    logic signed [ElemW-1:0] a11;
    logic signed [ElemW-1:0] a12;
    logic signed [ElemW-1:0] a20;
    logic signed [ElemW-1:0] a21;
    logic signed [ElemW-1:0] a22;
  } m3i_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] inv00;
    logic signed [ElemW-1:0] inv01;
    logic signed [ElemW-1:0] inv02;
    logic signed [ElemW-1:0] inv10;
    logic signed [ElemW-1:0] inv11;
    logic signed [ElemW-1:0] inv12;
    logic signed [ElemW-1:0] inv20;
    logic signed [ElemW-1:0] inv21;
    logic signed [ElemW-1:0] inv22;
    logic signed [ElemW-1:0] determinant;
    logic                    is_rotation;
    logic                    singular;
  } m3i_out_t;

endpackage
`default_nettype wire

### rtl/core/m3i_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_front
// Adjugate entries and rounded, saturated Q16.16 determinant, five stages.
// ----------------------------------------------------------------------------
module m3i_front (
  input  wire logic                          clk,
  input  wire m3i_pkg::m3i_in_t              mat,
  output logic signed [m3i_pkg::AdjW-1:0]    adj   [9],
  output logic signed [m3i_pkg::ElemW-1:0]   det
);
  import m3i_pkg::*;

  // adj[j] = a[PX]*a[PY] - a[QX]*a[QY]
  localparam int PX [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int PY [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int QX [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int QY [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  logic signed [ElemW-1:0] a [9];
  logic signed [AdjW-1:0]  pp [9];
  logic signed [AdjW-1:0]  pq [9];
  logic signed [ElemW-1:0] a_a [3];
  logic signed [ElemW-1:0] a_b [3];
  logic signed [AdjW-1:0]  adj_b [9];
  logic signed [AdjW-1:0]  adj_c [9];
  logic signed [AdjW-1:0]  adj_d [9];
  logic signed [AdjW-1:0]  ph [3];
  logic signed [AdjW:0]    pl [3];
  logic signed [96:0]      t_d [3];
  logic signed [97:0]      dsum;
  logic signed [65:0]      dsh;
  logic signed [ElemW-1:0] det_e;

  assign a = '{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12,
               mat.a20, mat.a21, mat.a22};

  always_ff @(posedge clk) begin
    for (int j = 0; j < 9; j++) begin
      pp[j]    <= AdjW'(a[PX[j]] * a[PY[j]]);
      pq[j]    <= AdjW'(a[QX[j]] * a[QY[j]]);
      adj_b[j] <= pp[j] - pq[j];
      adj_c[j] <= adj_b[j];
      adj_d[j] <= adj_c[j];
    end
    for (int k = 0; k < 3; k++) begin
      a_a[k] <= a[k];
      a_b[k] <= a_a[k];
    end
  end

  // det = a0*adj0 + a1*adj3 + a2*adj6, each 32x64 split into two 32-bit halves
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ph[k]  <= AdjW'(a_b[k] * $signed(adj_b[3*k][63:32]));
      pl[k]  <= (AdjW+1)'(a_b[k] * $signed({1'b0, adj_b[3*k][31:0]}));
      t_d[k] <= ($signed({{1{ph[k][AdjW-1]}}, ph[k]}) <<< 32)
                + 97'(pl[k]);
    end
  end

  always_comb begin
    dsum = 98'(t_d[0]) + 98'(t_d[1]) + 98'(t_d[2]) + 98'sh80000000;
    dsh  = dsum[97:32];
    if (dsh > 66'sh7FFFFFFF) begin
      det_e = 32'sh7FFFFFFF;
    end else if (dsh < -66'sh80000000) begin
      det_e = 32'sh80000000;
    end else begin
      det_e = dsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    det <= det_e;
    adj <= adj_d;
  end

endmodule
`default_nettype wire

### rtl/core/m3i_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_lane
// One inverse element: rounded adjugate / determinant, one quotient bit a stage.
// ----------------------------------------------------------------------------
module m3i_lane (
  input  wire logic                          clk,
  input  wire logic signed [m3i_pkg::AdjW-1:0]  adj,
  input  wire logic signed [m3i_pkg::ElemW-1:0] det,
  output logic signed [m3i_pkg::ElemW-1:0]   inv
);
  import m3i_pkg::*;

  logic [AdjW-1:0]  cm;
  logic [ElemW-1:0] dm_in;
  logic [AdjW-1:0]  num;

  logic [ElemW-1:0] r   [QuotW+1];
  logic [QuotW-1:0] n   [QuotW+1];
  logic [QuotW-1:0] q   [QuotW+1];
  logic [ElemW-1:0] dm  [QuotW+1];
  logic             neg [QuotW+1];
  logic             ovf [QuotW+1];
  logic             dz  [QuotW+1];

  logic [ElemW:0]   mag;

  assign cm    = adj[AdjW-1] ? AdjW'(-adj) : AdjW'(adj);
  assign dm_in = det[ElemW-1] ? ElemW'(-det) : ElemW'(det);
  assign num   = cm + AdjW'(dm_in >> 1);

  always_ff @(posedge clk) begin
    r[0]   <= ElemW'(num[AdjW-1:QuotW]);
    n[0]   <= num[QuotW-1:0];
    q[0]   <= '0;
    dm[0]  <= dm_in;
    neg[0] <= (adj[AdjW-1] != det[ElemW-1]) && (cm != '0);
    ovf[0] <= {1'b0, num} >= {dm_in, {QuotW{1'b0}}};
    dz[0]  <= (det == '0);
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_step
    logic [ElemW:0] r2;
    logic           ge;
    assign r2 = {r[s], n[s][QuotW-1]};
    assign ge = r2 >= {1'b0, dm[s]};
    always_ff @(posedge clk) begin
      r[s+1]   <= ge ? ElemW'(r2 - {1'b0, dm[s]}) : r2[ElemW-1:0];
      n[s+1]   <= n[s] << 1;
      q[s+1]   <= {q[s][QuotW-2:0], ge};
      dm[s+1]  <= dm[s];
      neg[s+1] <= neg[s];
      ovf[s+1] <= ovf[s];
      dz[s+1]  <= dz[s];
    end
  end

  always_comb begin
    mag = '0;
    if (dz[QuotW]) begin
      inv = '0;
    end else if (neg[QuotW]) begin
      mag = (ovf[QuotW] || q[QuotW] > 33'h80000000) ? 33'h80000000 : q[QuotW];
      inv = ElemW'(-mag);
    end else if (ovf[QuotW] || q[QuotW] > 33'h7FFFFFFF) begin
      inv = 32'sh7FFFFFFF;
    end else begin
      inv = q[QuotW][ElemW-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/matrix3_inverse_with_determinant.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse_with_determinant
// 3x3 Q16.16 inverse via adjugate, with determinant and rotation check.
// ----------------------------------------------------------------------------
// One item is accepted per cycle. Each item passes through the input register,
// the front end, the 33-step quotient pipeline in each of nine lanes and the
// output register. busy stays low; results cannot be stalled. Sync reset
// clears the valid pipe and sets det_tolerance to 7.
module matrix3_inverse_with_determinant (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire m3i_pkg::m3i_in_t        operands,
  output logic                         result_valid,
  output m3i_pkg::m3i_out_t            result,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [m3i_pkg::TolW-1:0] cfg_data
);
  import m3i_pkg::*;

  localparam int PipeLen = 1 + FrontLat + LaneLat;

  logic [TolW-1:0]         det_tolerance;
  m3i_in_t                 mat;
  logic [PipeLen-1:0]      vpipe;
  logic signed [AdjW-1:0]  adj [9];
  logic signed [ElemW-1:0] det;
  logic signed [ElemW-1:0] det_dly [LaneLat];
  logic signed [ElemW-1:0] inv [9];
  logic signed [ElemW:0]   diff;
  logic [ElemW:0]          diff_mag;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_tolerance <= TolReset;
      vpipe         <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        det_tolerance <= cfg_data;
      end
      vpipe        <= {vpipe[PipeLen-2:0], start && !busy};
      result_valid <= vpipe[PipeLen-1];
    end
  end

  always_ff @(posedge clk) begin
    mat <= operands;
  end

  m3i_front u_front (
    .clk (clk),
    .mat (mat),
    .adj (adj),
    .det (det)
  );

  for (genvar j = 0; j < 9; j++) begin : g_lane
    m3i_lane u_lane (
      .clk (clk),
      .adj (adj[j]),
      .det (det),
      .inv (inv[j])
    );
  end

  always_ff @(posedge clk) begin
    det_dly[0] <= det;
    for (int s = 1; s < LaneLat; s++) begin
      det_dly[s] <= det_dly[s-1];
    end
  end

  assign diff     = {det_dly[LaneLat-1][ElemW-1], det_dly[LaneLat-1]} - OneQ16;
  assign diff_mag = diff[ElemW] ? (ElemW+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    result.inv00       <= inv[0];
    result.inv01       <= inv[1];
    result.inv02       <= inv[2];
    result.inv10       <= inv[3];
    result.inv11       <= inv[4];
    result.inv12       <= inv[5];
    result.inv20       <= inv[6];
    result.inv21       <= inv[7];
    result.inv22       <= inv[8];
    result.determinant <= det_dly[LaneLat-1];
    result.is_rotation <= diff_mag <= {{(ElemW+1-TolW){1'b0}}, det_tolerance};
    result.singular    <= (det_dly[LaneLat-1] == '0);
  end

endmodule
`default_nettype wire
